// ===== sv/nbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Negative base converter package
// Shared types and fixed constants for the negative base converter blocks.
// ----------------------------------------------------------------------------
package nbc_pkg;

   // Widths of the result fields.
   localparam int DIGIT_BITS = 5;
   localparam int POS_BITS   = 5;

   // Configuration register layout.
   localparam int BASE_BITS     = 6;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_NEG_BASE = 1'b0;

   // Legal radix range and the radix after reset.
   localparam logic signed [BASE_BITS-1:0] BASE_RESET = -6'sd2;
   localparam logic signed [BASE_BITS-1:0] BASE_HIGH  = -6'sd2;
   localparam logic signed [BASE_BITS-1:0] BASE_LOW   = -6'sd20;
   localparam logic [DIGIT_BITS-1:0] MAG_MIN = 5'd2;
   localparam logic [DIGIT_BITS-1:0] MAG_MAX = 5'd20;

   // Quotient bits the shared divider retires per cycle.
   localparam int DIV_STEP_BITS = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_READ,
      ST_SHOW
   } nbc_state_type;

endpackage

// ===== sv/nbc_divider.sv =====
// ----------------------------------------------------------------------------
// Shared iterative divider
// Divides an unsigned magnitude by a small divisor, eight quotient bits per
// cycle, and pulses done when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module nbc_divider #(
   parameter int WIDTH = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [WIDTH-1:0]              dividend,
   input  logic [nbc_pkg::DIGIT_BITS-1:0] divisor,
   output logic                          done,
   output logic [WIDTH-1:0]              quotient,
   output logic [nbc_pkg::DIGIT_BITS-1:0] remainder
);
   import nbc_pkg::*;

   localparam int STEPS = (WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int PAD   = STEPS * DIV_STEP_BITS;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PAD-1:0]        dvd_ff, dvd_in;
   logic [DIGIT_BITS-1:0] part_ff, part_in;
   logic [DIGIT_BITS-1:0] dvs_ff, dvs_in;

   logic [DIGIT_BITS:0]   part_v;
   logic [PAD-1:0]        dvd_v;

   // Restoring division: the partial remainder stays below the divisor, so
   // each compare and subtract works on six bits only.
   always_comb begin
      part_v = {1'b0, part_ff};
      dvd_v  = dvd_ff;
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
         part_v = {part_v[DIGIT_BITS-1:0], dvd_v[PAD-1]};
         dvd_v  = {dvd_v[PAD-2:0], 1'b0};
         if (part_v >= {1'b0, dvs_ff}) begin
            part_v   = part_v - {1'b0, dvs_ff};
            dvd_v[0] = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      part_in = part_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS - 1);
         dvd_in  = PAD'(dividend);
         part_in = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in  = dvd_v;
         part_in = part_v[DIGIT_BITS-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff  <= dvd_in;
      part_ff <= part_in;
      dvs_ff  <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff[WIDTH-1:0];
   assign remainder = part_ff;

endmodule

// ===== sv/nbc_digit_ram.sv =====
// ----------------------------------------------------------------------------
// Digit buffer
// One write port and one registered read port holding the digits of the
// current conversion, least significant digit at address zero.
// ----------------------------------------------------------------------------
module nbc_digit_ram #(
   parameter int DEPTH = 20
) (
   input  logic                           clock,
   input  logic                           we,
   input  logic [$clog2(DEPTH)-1:0]       waddr,
   input  logic [nbc_pkg::DIGIT_BITS-1:0] wdata,
   input  logic                           re,
   input  logic [$clog2(DEPTH)-1:0]       raddr,
   output logic [nbc_pkg::DIGIT_BITS-1:0] rdata_ff
);
   import nbc_pkg::*;

   logic [DIGIT_BITS-1:0] digit_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         digit_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= digit_mem[raddr];
      end
   end

endmodule

// ===== sv/negative_base_converter.sv =====
// ----------------------------------------------------------------------------
// Negative base converter
// Converts a signed integer to its digits in a programmable negative radix.
// ----------------------------------------------------------------------------
// Each accepted value is rewritten in the radix held in the neg_base register
// (-2 to -20; values above -2 act as -2, values below -20 as -20). The block
// then sends one beat per digit, most significant digit first, each with its
// position (0 is least significant) and with last set on the position 0 beat.
// A zero input sends a single 0 digit. The block takes one value at a time and
// holds req_stall high from acceptance until its final digit beat is taken.
// Digits come from one shared divider that retires eight quotient bits per
// cycle. Each digit beat passes through a registered digit buffer read and
// holds while the consumer stalls. At the default width a radix -2 conversion
// runs to at most 18 digits (for values near -65536), and radix -10 needs at
// most 6 digits. If a value needs more than MAX_DIGITS digits, only the
// MAX_DIGITS least significant digits are sent. Positions wider than five bits
// wrap. The neg_base register sits at byte address 0 of the APB-style port and
// should only be written while no conversion is in flight.
// ----------------------------------------------------------------------------
module negative_base_converter #(
   parameter int MAX_DIGITS = 20,
   parameter int VALUE_BITS = 17
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [VALUE_BITS-1:0]      req_value,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nbc_pkg::DIGIT_BITS-1:0]    rsp_digit,
   output logic [nbc_pkg::POS_BITS-1:0]      rsp_position,
   output logic                              rsp_last,
   // Configuration port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nbc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [nbc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [nbc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import nbc_pkg::*;

   localparam int REM_BITS  = VALUE_BITS + 1;
   localparam int ADDR_BITS = $clog2(MAX_DIGITS);
   localparam int CNT_BITS  = $clog2(MAX_DIGITS + 1);

   nbc_state_type state_ff, state_in;

   logic signed [BASE_BITS-1:0] neg_base_ff;
   logic [DIGIT_BITS-1:0]       mag_ff, mag_in;
   logic signed [REM_BITS-1:0]  rem_ff, rem_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic [ADDR_BITS-1:0]        idx_ff, idx_in;

   logic                        req_acc;
   logic                        csr_wr;
   logic [DIGIT_BITS-1:0]       mag_sat;
   logic                        rem_zero;
   logic                        digits_done;

   logic                        div_start;
   logic                        div_done;
   logic [REM_BITS-1:0]         div_dividend;
   logic [REM_BITS-1:0]         div_quot;
   logic [DIGIT_BITS-1:0]       div_rem;

   logic [DIGIT_BITS-1:0]       digit_fix;
   logic signed [REM_BITS-1:0]  rem_next;

   logic                        ram_we;
   logic [DIGIT_BITS-1:0]       ram_wdata;
   logic                        ram_re;
   logic [DIGIT_BITS-1:0]       ram_rdata;

   // ------------------------------------------------------------------------
   // Configuration register. Reads return the radix sign-extended to 32 bits.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_base_ff <= BASE_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_NEG_BASE)) begin
         neg_base_ff <= csr_pwdata[BASE_BITS-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_NEG_BASE) begin
         csr_prdata = {{(CSR_DATA_BITS-BASE_BITS){neg_base_ff[BASE_BITS-1]}}, neg_base_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // The radix is clamped into the legal range and kept as a magnitude,
   // captured when a value is accepted.
   always_comb begin
      if (neg_base_ff > BASE_HIGH) begin
         mag_sat = MAG_MIN;
      end else if (neg_base_ff < BASE_LOW) begin
         mag_sat = MAG_MAX;
      end else begin
         mag_sat = DIGIT_BITS'(-neg_base_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Shared divider. It divides the magnitude of the remaining value by the
   // radix magnitude; the signs are applied afterwards.
   // ------------------------------------------------------------------------
   assign div_dividend = rem_ff[REM_BITS-1] ? $unsigned(-rem_ff) : $unsigned(rem_ff);

   nbc_divider #(
      .WIDTH (REM_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (mag_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Turn the unsigned division into a negative-radix digit. A positive value
   // has a nonnegative remainder and a negated quotient. A negative value with
   // a nonzero remainder is corrected by taking the complement digit and
   // rounding the quotient up by one.
   always_comb begin
      if (!rem_ff[REM_BITS-1]) begin
         digit_fix = div_rem;
         rem_next  = $signed(REM_BITS'(0) - div_quot);
      end else if (div_rem == '0) begin
         digit_fix = '0;
         rem_next  = $signed(div_quot);
      end else begin
         digit_fix = mag_ff - div_rem;
         rem_next  = $signed(div_quot + REM_BITS'(1));
      end
   end

   // ------------------------------------------------------------------------
   // Digit buffer, filled least significant first and read back in reverse.
   // ------------------------------------------------------------------------
   nbc_digit_ram #(
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (count_ff[ADDR_BITS-1:0]),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr    (idx_ff),
      .rdata_ff (ram_rdata)
   );

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   assign rem_zero    = (rem_ff == '0);
   assign digits_done = rem_zero || (count_ff == CNT_BITS'(MAX_DIGITS));
   assign req_acc     = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (rem_zero && (count_ff == '0)) begin
               state_in = ST_LOAD;
            end else if (digits_done) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               state_in = (idx_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = reset || (state_ff != ST_IDLE);
      rsp_valid = !reset && (state_ff == ST_SHOW);
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      div_start = 1'b0;
      ram_we    = 1'b0;
      ram_wdata = digit_fix;
      ram_re    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rem_in   = {req_value[VALUE_BITS-1], req_value};
               count_in = '0;
               mag_in   = mag_sat;
            end
         end
         ST_LOAD: begin
            if (rem_zero && (count_ff == '0)) begin
               // A zero input still yields one digit.
               ram_we    = 1'b1;
               ram_wdata = '0;
               count_in  = CNT_BITS'(1);
            end else if (digits_done) begin
               idx_in = ADDR_BITS'(count_ff - CNT_BITS'(1));
            end else begin
               div_start = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               ram_we   = 1'b1;
               count_in = count_ff + CNT_BITS'(1);
               rem_in   = rem_next;
            end
         end
         ST_READ: begin
            ram_re = 1'b1;
         end
         ST_SHOW: begin
            if (!rsp_stall && (idx_ff != '0)) begin
               idx_in = idx_ff - ADDR_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rem_ff   <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
      mag_ff <= mag_in;
   end

   // The beat fields come straight from registers, so they hold while the
   // consumer stalls.
   assign rsp_digit    = ram_rdata;
   assign rsp_position = POS_BITS'(idx_ff);
   assign rsp_last     = (idx_ff == '0);

endmodule

// ===== sv/nbc_checker.sv =====
// ----------------------------------------------------------------------------
// Negative base converter checker
// Port-level assertions on the converter's beat sequencing, bound to the top.
// ----------------------------------------------------------------------------
module nbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [nbc_pkg::DIGIT_BITS-1:0] rsp_digit,
   input logic [nbc_pkg::POS_BITS-1:0]   rsp_position,
   input logic                           rsp_last
);
   import nbc_pkg::*;

   // A stalled digit beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit)
         && $stable(rsp_position) && $stable(rsp_last))
      else $error("stalled digit beat changed");

   // No new value is taken while digits are being sent.
   a_no_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during digit output");

   // An accepted value closes the input until its run is done.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("input not held off after acceptance");

   // The run ends after the last beat.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_stall |=> !rsp_valid)
      else $error("digit beat after the last mark");

   // Positions step down by one from beat to beat.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> !rsp_valid ##1
         (rsp_valid && (rsp_position == POS_BITS'($past(rsp_position, 2) - 1'b1))))
      else $error("digit position out of sequence");

endmodule

bind negative_base_converter nbc_checker u_nbc_checker (.*);
